// ===== hdl/pda_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pda_pkg
// Shared widths, codes, types and constants of the periodic dipole accumulator.
// ---------------------------------------------------------------------------
package pda_pkg;

	localparam int COORD_W    = 24;
	localparam int ACC_W      = 48;
	localparam int OUT_W      = 48;
	localparam int BOX_W      = 23;
	localparam int CHARGE_W   = 16;
	localparam int NUM_AXES   = 3;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int MAG_W      = COORD_W;
	localparam int PROD_W     = DIFF_W + CHARGE_W;
	localparam int SHIFT_W    = MAG_W + BOX_W;
	localparam int FOLD_SPC   = 4;
	localparam int FOLD_CYC   = (MAG_W + FOLD_SPC - 1) / FOLD_SPC;
	localparam int FOLD_CNT_W = $clog2(FOLD_CYC + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [BOX_W-1:0]           BOX_RESET    = BOX_W'(409600);
	localparam logic signed [CHARGE_W-1:0] WANNIER_Q    = -CHARGE_W'(2048);
	localparam logic                       KIND_WANNIER = 1'b1;

	typedef enum logic [1:0] {
		REG_BOX_X = 2'd0,
		REG_BOX_Y = 2'd1,
		REG_BOX_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                       kind;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic signed [CHARGE_W-1:0] charge;
		logic signed [COORD_W-1:0]  com_x;
		logic signed [COORD_W-1:0]  com_y;
		logic signed [COORD_W-1:0]  com_z;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] dipole_x;
		logic signed [OUT_W-1:0] dipole_y;
		logic signed [OUT_W-1:0] dipole_z;
	} out_item_t;

	// one classified point: sign and magnitude of pos - com per axis
	typedef struct packed {
		logic [NUM_AXES-1:0]            neg;
		logic [NUM_AXES-1:0][MAG_W-1:0] mag;
		logic signed [CHARGE_W-1:0]     q;
		logic                           last;
	} work_item_t;

	typedef logic [NUM_AXES-1:0][BOX_W-1:0] box_set_t;

endpackage

// ===== hdl/pda_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pda_front
// Classifies a request: charge selection and per-axis offset from the centre.
// ---------------------------------------------------------------------------
module pda_front (
	input  pda_pkg::in_item_t   item,
	output pda_pkg::work_item_t work
);

	logic signed [pda_pkg::COORD_W-1:0] pos  [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::COORD_W-1:0] com  [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::DIFF_W-1:0]  diff [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::DIFF_W-1:0]  absd [pda_pkg::NUM_AXES];

	always_comb begin
		pos[0] = item.pos_x;
		pos[1] = item.pos_y;
		pos[2] = item.pos_z;
		com[0] = item.com_x;
		com[1] = item.com_y;
		com[2] = item.com_z;
		for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
			diff[a] = pda_pkg::DIFF_W'(pos[a]) - pda_pkg::DIFF_W'(com[a]);
			absd[a] = diff[a][pda_pkg::DIFF_W-1] ? -diff[a] : diff[a];
			work.neg[a] = diff[a][pda_pkg::DIFF_W-1];
			// |pos - com| never reaches 2^COORD_W
			work.mag[a] = absd[a][pda_pkg::MAG_W-1:0];
		end
		work.q    = (item.kind == pda_pkg::KIND_WANNIER) ? pda_pkg::WANNIER_Q : item.charge;
		work.last = item.last;
	end

endmodule

// ===== hdl/pda_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pda_fifo
// Two-entry queue of classified points between front and back.
// ---------------------------------------------------------------------------
module pda_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pda_pkg::work_item_t push_data,
	output logic                full,
	input  logic                pop,
	output pda_pkg::work_item_t pop_data,
	output logic                empty
);

	pda_pkg::work_item_t                 mem [pda_pkg::FIFO_DEPTH];
	logic [pda_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [pda_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [pda_pkg::FIFO_CNT_W-1:0]      count_q;

	assign full     = (count_q == pda_pkg::FIFO_CNT_W'(pda_pkg::FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pda_pkg::FIFO_PTR_W'(pda_pkg::FIFO_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pda_pkg::FIFO_PTR_W'(pda_pkg::FIFO_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/pda_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pda_back
// Minimum-image fold, charge multiply and saturating dipole accumulation.
// ---------------------------------------------------------------------------
module pda_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pda_pkg::box_set_t   box,
	input  logic                fifo_empty,
	input  pda_pkg::work_item_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output pda_pkg::out_item_t  out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FOLD,
		ST_MUL,
		ST_ACC
	} state_t;

	state_t                                state_q;
	logic [pda_pkg::FOLD_CNT_W-1:0]        cnt_q;
	pda_pkg::work_item_t                   cur_q;
	logic [pda_pkg::MAG_W-1:0]             rem_q  [pda_pkg::NUM_AXES];
	logic [pda_pkg::MAG_W-1:0]             rem_n  [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::PROD_W-1:0]     prod_q [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::PROD_W-1:0]     prod_n [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::ACC_W-1:0]      sum_q  [pda_pkg::NUM_AXES];
	logic signed [pda_pkg::ACC_W-1:0]      sat_n  [pda_pkg::NUM_AXES];
	logic                                  out_valid_q;
	pda_pkg::out_item_t                    out_q;
	logic                                  acc_go;
	logic                                  emit;
	logic                                  load;

	assign acc_go    = (state_q == ST_ACC) && (!cur_q.last || !out_valid_q || !out_stall);
	assign emit      = acc_go && cur_q.last;
	assign load      = !fifo_empty && ((state_q == ST_IDLE) || acc_go);
	assign pop       = load;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// restoring remainder: FOLD_SPC shifted-box compare/subtracts per cycle
	always_comb begin
		logic [pda_pkg::SHIFT_W-1:0] rw;
		logic [pda_pkg::SHIFT_W-1:0] shb;
		int                          bitpos;
		for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
			rw = pda_pkg::SHIFT_W'(rem_q[a]);
			for (int j = 0; j < pda_pkg::FOLD_SPC; j++) begin
				bitpos = pda_pkg::MAG_W - 1 - (int'(cnt_q) * pda_pkg::FOLD_SPC + j);
				shb    = pda_pkg::SHIFT_W'(box[a]) << bitpos[$clog2(pda_pkg::SHIFT_W):0];
				if (bitpos >= 0 && rw >= shb) begin
					rw = rw - shb;
				end
			end
			rem_n[a] = rw[pda_pkg::MAG_W-1:0];
		end
	end

	// remainder above half a box wraps to the negative side; zero box leaves d alone
	always_comb begin
		logic signed [pda_pkg::DIFF_W-1:0] f0;
		logic signed [pda_pkg::DIFF_W-1:0] f;
		logic [pda_pkg::MAG_W:0]           twice;
		for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
			twice = {rem_q[a], 1'b0};
			if (box[a] == '0) begin
				f0 = pda_pkg::DIFF_W'(cur_q.mag[a]);
			end else if (twice > (pda_pkg::MAG_W + 1)'(box[a])) begin
				f0 = pda_pkg::DIFF_W'(rem_q[a]) - pda_pkg::DIFF_W'(box[a]);
			end else begin
				f0 = pda_pkg::DIFF_W'(rem_q[a]);
			end
			f = cur_q.neg[a] ? -f0 : f0;
			prod_n[a] = f * cur_q.q;
		end
	end

	always_comb begin
		logic signed [pda_pkg::ACC_W:0] wide;
		for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
			wide = (pda_pkg::ACC_W + 1)'(sum_q[a]) + (pda_pkg::ACC_W + 1)'(prod_q[a]);
			if (wide[pda_pkg::ACC_W] != wide[pda_pkg::ACC_W-1]) begin
				sat_n[a] = wide[pda_pkg::ACC_W]
					? {1'b1, {(pda_pkg::ACC_W - 1){1'b0}}}
					: {1'b0, {(pda_pkg::ACC_W - 1){1'b1}}};
			end else begin
				sat_n[a] = wide[pda_pkg::ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
				rem_q[a]  <= '0;
				prod_q[a] <= '0;
				sum_q[a]  <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
						rem_q[a] <= rem_n[a];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pda_pkg::FOLD_CNT_W'(pda_pkg::FOLD_CYC - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
						prod_q[a] <= prod_n[a];
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (acc_go) begin
						if (cur_q.last) begin
							out_q.dipole_x <= pda_pkg::OUT_W'(sat_n[0]);
							out_q.dipole_y <= pda_pkg::OUT_W'(sat_n[1]);
							out_q.dipole_z <= pda_pkg::OUT_W'(sat_n[2]);
							for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
								sum_q[a] <= '0;
							end
						end else begin
							for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
								sum_q[a] <= sat_n[a];
							end
						end
						state_q <= load ? ST_FOLD : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				cur_q <= head;
				cnt_q <= '0;
				for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
					rem_q[a] <= head.mag[a];
				end
			end
		end
	end

endmodule

// ===== hdl/periodic_dipole_accumulator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_dipole_accumulator
// Minimum-image molecular dipole sum over a stream of atoms and Wannier centres.
// ---------------------------------------------------------------------------
// Each point goes through the back end in order: remainder folding against the
// box length (4 quotient bits per cycle over the 24-bit offset magnitude, all
// three axes in parallel), the charge multiply and the saturating accumulate.
// The back end holds one point at a time; a request is popped from the
// two-entry queue in the same cycle the previous one accumulates. When the
// back end has gone idle it picks up the next request in its idle state
// before folding. The front takes requests while the queue has room, so up
// to two points wait while the result register is stalled. The result for a
// molecule appears the cycle after its last point accumulates and holds until
// taken. Box lengths are read and written at byte addresses 0, 4 and 8; write
// them only when the block is idle. No clearing pass is needed after reset.
module periodic_dipole_accumulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pda_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pda_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pda_pkg::ADDR_W-1:0]    paddr,
	input  logic [pda_pkg::DATA_W-1:0]    pwdata,
	output logic [pda_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	pda_pkg::box_set_t   box_q;
	pda_pkg::work_item_t front_work;
	pda_pkg::work_item_t head;
	logic                fifo_full;
	logic                fifo_empty;
	logic                pop;
	logic                push;
	logic                cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < pda_pkg::NUM_AXES; a++) begin
				box_q[a] <= pda_pkg::BOX_RESET;
			end
		end else if (cfg_wr) begin
			case (paddr[3:2])
				pda_pkg::REG_BOX_X: box_q[0] <= pwdata[pda_pkg::BOX_W-1:0];
				pda_pkg::REG_BOX_Y: box_q[1] <= pwdata[pda_pkg::BOX_W-1:0];
				pda_pkg::REG_BOX_Z: box_q[2] <= pwdata[pda_pkg::BOX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pda_pkg::REG_BOX_X: prdata = pda_pkg::DATA_W'(box_q[0]);
			pda_pkg::REG_BOX_Y: prdata = pda_pkg::DATA_W'(box_q[1]);
			pda_pkg::REG_BOX_Z: prdata = pda_pkg::DATA_W'(box_q[2]);
			default:            prdata = '0;
		endcase
	end

	pda_front u_front (
		.item (in_data),
		.work (front_work)
	);

	pda_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_work),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (fifo_empty)
	);

	pda_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.box        (box_q),
		.fifo_empty (fifo_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ===== hdl/pda_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pda_checker
// Port-level checks of the periodic dipole accumulator, bound to the top level.
// ---------------------------------------------------------------------------
module pda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input pda_pkg::out_item_t            out_data,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [pda_pkg::ADDR_W-1:0]    paddr,
	input logic [pda_pkg::DATA_W-1:0]    pwdata,
	input logic [pda_pkg::DATA_W-1:0]    prdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// the queue only fills on a request taken the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("stall raised without a request");

	// nothing pending right after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid && !in_stall)
		else $error("block busy right after reset");

	// a box register reads back what was just written to it
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite) && ($past(paddr[3:2]) != 2'd3)
		&& (paddr == $past(paddr)) && !pwrite
		|-> prdata == pda_pkg::DATA_W'($past(pwdata[pda_pkg::BOX_W-1:0])))
		else $error("box register readback mismatch");

endmodule

bind periodic_dipole_accumulator pda_checker u_pda_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic dipole accumulator.
// ---------------------------------------------------------------------------
// Points are fed through the valid/stall request port and predicted in the
// bench: per-axis minimum-image offset, scaled by charge, summed into a
// saturating 48-bit dipole. Each dipole coming out is checked field by field
// against the oldest predicted one.
// Coverage:
//   - a short table of hand-picked points, with the dipole typed in where it
//     is obvious
//   - a zero-box molecule long enough to drive x and y into saturation
//   - random molecules under several box settings, including the extremes
// Both ports pause at random, and box lengths are written over APB and
// read back.
// ---------------------------------------------------------------------------
module tb;
	import pda_pkg::*;

	localparam int     LIMIT     = 300000;
	localparam int     SETTLE    = 24;
	localparam int     PHASE_PTS = 70;
	localparam int     SAT_PTS   = 286;
	localparam logic   KIND_ATOM = 1'b0;
	localparam longint PMAX      = 8388607;
	localparam longint PMIN      = -8388608;
	localparam longint QMAX      = 32767;
	localparam longint QMIN      = -32768;
	localparam longint ACC_HI    = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO    = -ACC_HI - 1;
	localparam longint BOX_MAX   = (longint'(1) <<< BOX_W) - 1;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} point_req_t;

	// hand-written row: kind, pos xyz, charge, com xyz, last, typed, dipole xyz
	typedef struct {
		logic   kind;
		longint px, py, pz;
		longint q;
		longint cx, cy, cz;
		bit     last;
		bit     typed;
		longint wx, wy, wz;
	} point_row_t;

	point_row_t point_tbl [14] = '{
		'{KIND_ATOM,    0, 0, 0,                 0,    0, 0, 0,  1, 1, 0, 0, 0},
		'{KIND_ATOM,    4096, 0, 0,              1024, 0, 0, 0,  1, 1, 4194304, 0, 0},
		'{KIND_WANNIER, 5000, -4000, 777,        QMAX, 904, 96, 777,
			1, 1, -8388608, 8388608, 0},
		'{KIND_ATOM,    204800, -204800, 204801, 1,    0, 0, 0,
			1, 1, 204800, -204800, -204799},
		'{KIND_ATOM,    1228800, 413696, -413696, 1024, 0, 0, 0,
			1, 1, 0, 4194304, -4194304},
		'{KIND_ATOM,    PMAX, PMIN, PMAX,        QMAX, PMIN, PMAX, PMAX, 0, 0, 0, 0, 0},
		'{KIND_ATOM,    PMAX, PMIN, -1,          QMIN, PMIN, PMAX, 0,    0, 0, 0, 0, 0},
		'{KIND_WANNIER, PMIN, PMAX, PMIN,        QMIN, PMAX, PMIN, PMAX, 1, 0, 0, 0, 0},
		'{KIND_ATOM,    PMAX, PMAX, PMAX,        QMIN, PMAX, PMAX, PMAX, 1, 1, 0, 0, 0},
		'{KIND_WANNIER, PMIN, PMIN, PMIN,        QMAX, PMIN, PMIN, PMIN, 1, 1, 0, 0, 0},
		'{KIND_ATOM,    -204800, 204800, -204801, QMIN, 0, 0, 0,     0, 0, 0, 0, 0},
		'{KIND_ATOM,    1000, -2000, 3000,       -1, -409600, 409600, 819200, 0, 0, 0, 0, 0},
		'{KIND_WANNIER, 123456, -654321, 4194303, 0, -4194304, 4194303, -4194304,
			0, 0, 0, 0, 0},
		'{KIND_ATOM,    7, 8, 9,                 QMAX, 0, 0, 0,  1, 0, 0, 0, 0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	point_req_t          point_q[$];
	out_item_t           dipole_q[$];
	longint              dipole_acc [NUM_AXES];
	longint              box_len [NUM_AXES];
	bit                  calm;
	int                  errors;
	int                  cycles;
	int                  points_queued;
	int                  points_taken;
	int                  dipoles_seen;
	int                  box_writes;

	periodic_dipole_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("periodic_dipole_accumulator test failed");
			$finish;
		end
	end

	function automatic int hold_cycles();
		return calm ? 0 : int'($urandom_range(0, 4));
	endfunction

	// minimum image: half a box is kept, anything beyond folds by whole boxes
	function automatic longint wrap_offset(longint d, longint b);
		longint e;
		longint k;
		bit     neg;
		if (b == 0)
			return d;
		neg = d < 0;
		e = neg ? -d : d;
		if (2 * e <= b)
			return d;
		k = (2 * e + b - 1) / (2 * b);
		e -= k * b;
		return neg ? -e : e;
	endfunction

	function automatic longint sat_acc(longint s, longint p);
		if (p > 0 && s > ACC_HI - p)
			return ACC_HI;
		if (p < 0 && s < ACC_LO - p)
			return ACC_LO;
		return s + p;
	endfunction

	function automatic void fold_in_point(point_req_t r);
		longint    pos [NUM_AXES];
		longint    com [NUM_AXES];
		longint    q;
		out_item_t p;
		pos[0] = longint'($signed(r.item.pos_x));
		pos[1] = longint'($signed(r.item.pos_y));
		pos[2] = longint'($signed(r.item.pos_z));
		com[0] = longint'($signed(r.item.com_x));
		com[1] = longint'($signed(r.item.com_y));
		com[2] = longint'($signed(r.item.com_z));
		q = (r.item.kind == KIND_WANNIER) ? longint'(WANNIER_Q) :
			longint'($signed(r.item.charge));
		for (int a = 0; a < NUM_AXES; a++)
			dipole_acc[a] = sat_acc(dipole_acc[a],
				wrap_offset(pos[a] - com[a], box_len[a]) * q);
		if (r.item.last) begin
			p.dipole_x = OUT_W'(dipole_acc[0]);
			p.dipole_y = OUT_W'(dipole_acc[1]);
			p.dipole_z = OUT_W'(dipole_acc[2]);
			dipole_q.insert(dipole_q.size(), r.typed ? r.want : p);
			for (int a = 0; a < NUM_AXES; a++)
				dipole_acc[a] = 0;
		end
	endfunction

	function automatic void queue_point(in_item_t it, bit typed, out_item_t want);
		point_req_t r;
		r.item  = it;
		r.typed = typed;
		r.want  = want;
		point_q.insert(point_q.size(), r);
		points_queued++;
	endfunction

	function automatic in_item_t make_point(logic kind, longint px, longint py, longint pz,
		longint q, longint cx, longint cy, longint cz, bit last);
		in_item_t it;
		it.kind   = kind;
		it.pos_x  = COORD_W'(px);
		it.pos_y  = COORD_W'(py);
		it.pos_z  = COORD_W'(pz);
		it.charge = CHARGE_W'(q);
		it.com_x  = COORD_W'(cx);
		it.com_y  = COORD_W'(cy);
		it.com_z  = COORD_W'(cz);
		it.last   = last;
		return it;
	endfunction

	// offsets aimed at the folding corners: inside, exactly half, whole boxes
	function automatic longint pick_pos(longint com, longint b);
		longint half;
		longint k;
		case ($urandom_range(0, 3))
			0: return longint'($signed(COORD_W'($urandom)));
			1: begin
				if (b == 0)
					return com + longint'($urandom_range(0, 8192)) - 4096;
				return com + longint'($urandom_range(0, 2 * b + 4)) - b - 2;
			end
			2: begin
				half = $urandom_range(0, 1) ? b / 2 : (b + 1) / 2;
				k = $urandom_range(0, 3);
				return $urandom_range(0, 1) ? com + k * b + half : com - k * b - half;
			end
			default: return com + (longint'($urandom_range(0, 8)) - 4) * b;
		endcase
	endfunction

	function automatic in_item_t rand_point(bit last);
		longint com [NUM_AXES];
		longint pos [NUM_AXES];
		logic   kind;
		for (int a = 0; a < NUM_AXES; a++) begin
			com[a] = longint'($signed(COORD_W'($urandom)));
			pos[a] = pick_pos(com[a], box_len[a]);
		end
		kind = ($urandom_range(0, 3) == 0) ? KIND_WANNIER : KIND_ATOM;
		return make_point(kind, pos[0], pos[1], pos[2],
			longint'($signed(CHARGE_W'($urandom))), com[0], com[1], com[2], last);
	endfunction

	task automatic write_box(reg_idx_t idx, longint v);
		logic [DATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		box_len[idx] = v & BOX_MAX;
		box_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		if (rd != DATA_W'(box_len[idx])) begin
			$error("box readback %s: expected %0d, got %0d", idx.name(), box_len[idx], rd);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_boxes(longint bx, longint by, longint bz);
		write_box(REG_BOX_X, bx);
		write_box(REG_BOX_Y, by);
		write_box(REG_BOX_Z, bz);
	endtask

	// let every queued point go in and every dipole come out
	task automatic settle();
		@(posedge clk);
		while (point_q.size() != 0 || points_taken != points_queued || dipole_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_molecules(int n);
		int len;
		int sent;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(0, 4) == 0) ? 1 : int'($urandom_range(2, 8));
			for (int j = 0; j < len; j++)
				queue_point(rand_point(j == len - 1), 1'b0, '0);
			sent += len;
		end
	endtask

	// point feeder
	initial begin : feeder
		point_req_t r;
		int         gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (point_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				r = point_q.pop_front();
				gap = hold_cycles();
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				in_valid <= 1'b1;
				in_data  <= r.item;
				@(posedge clk);
				while (in_stall) @(posedge clk);
				fold_in_point(r);
				points_taken++;
			end
		end
	end

	// result side back-pressure
	initial begin : sink
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = hold_cycles();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : dipole_check
		out_item_t w;
		if (arst_n && out_valid && !out_stall) begin
			dipoles_seen++;
			if (dipole_q.size() == 0) begin
				$error("dipole with none pending: x %0d y %0d z %0d",
					out_data.dipole_x, out_data.dipole_y, out_data.dipole_z);
				errors++;
			end else begin
				w = dipole_q.pop_front();
				if (out_data.dipole_x !== w.dipole_x) begin
					$error("dipole_x: expected %0d, got %0d", w.dipole_x, out_data.dipole_x);
					errors++;
				end
				if (out_data.dipole_y !== w.dipole_y) begin
					$error("dipole_y: expected %0d, got %0d", w.dipole_y, out_data.dipole_y);
					errors++;
				end
				if (out_data.dipole_z !== w.dipole_z) begin
					$error("dipole_z: expected %0d, got %0d", w.dipole_z, out_data.dipole_z);
					errors++;
				end
			end
		end
	end

	initial begin
		point_row_t row;
		out_item_t  want;
		longint     drift;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		calm      = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			box_len[a]    = BOX_RESET;
			dipole_acc[a] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hand-picked points under the reset box
		foreach (point_tbl[i]) begin
			row = point_tbl[i];
			want.dipole_x = OUT_W'(row.wx);
			want.dipole_y = OUT_W'(row.wy);
			want.dipole_z = OUT_W'(row.wz);
			queue_point(make_point(row.kind, row.px, row.py, row.pz, row.q,
				row.cx, row.cy, row.cz, row.last), row.typed, want);
		end
		settle();

		// zero box leaves offsets unfolded; full-span offsets saturate x high, y low
		set_boxes(0, 0, 0);
		for (int i = 0; i < SAT_PTS; i++) begin
			drift = $urandom_range(0, 3);
			queue_point(make_point(KIND_ATOM, PMAX - drift, PMIN + drift,
				longint'($signed(COORD_W'($urandom))),
				(i < SAT_PTS - 6) ? QMAX - drift : QMIN,
				PMIN + drift, PMAX - drift, longint'($signed(COORD_W'($urandom))),
				i == SAT_PTS - 1), 1'b0, '0);
		end
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 1);
			case (ph)
				0: set_boxes(1, BOX_MAX, BOX_RESET);
				1: set_boxes($urandom_range(1, BOX_MAX), $urandom_range(1, BOX_MAX),
					$urandom_range(1, BOX_MAX));
				2: set_boxes($urandom_range(1, 8192), $urandom_range(1, 8192),
					$urandom_range(1, 8192));
				default: set_boxes(BOX_MAX, 1, $urandom_range(1, BOX_MAX));
			endcase
			random_molecules(PHASE_PTS);
			settle();
		end

		$display("fed %0d points, checked %0d dipoles over %0d box writes",
			points_taken, dipoles_seen, box_writes);
		$display("phases: hand-picked table, zero-box saturation, four random box settings");
		if (errors == 0)
			$display("periodic_dipole_accumulator test passed");
		else
			$display("periodic_dipole_accumulator test failed");
		$finish;
	end

endmodule

// ===== periodic_dipole_accumulator.f =====
hdl/pda_pkg.sv
hdl/pda_front.sv
hdl/pda_fifo.sv
hdl/pda_back.sv
hdl/periodic_dipole_accumulator.sv
hdl/pda_checker.sv
tb/sv/tb.sv
